[design/ufp_pkg.sv]
// Shared types and constants for the serial frame parser.
// No dependencies.
package ufp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned CFG_IW  = 2;

  localparam logic [CFG_IW-1:0] CFG_HEAD_HIGH = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEAD_LOW  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_TAIL      = 2'd2;

  localparam logic [BYTE_W-1:0] HEAD_HIGH_RST = 8'd170;
  localparam logic [BYTE_W-1:0] HEAD_LOW_RST  = 8'd85;
  localparam logic [BYTE_W-1:0] TAIL_RST      = 8'd187;

  typedef struct packed {
    logic               bank;
    logic [FIELD_W-1:0] len;
  } ufp_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } ufp_release_t;

endpackage

[design/ufp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[design/ufp_front.sv]
// Front end: configuration registers, frame hunt, checksum and frame store writes.
// Depends on ufp_pkg.
module ufp_front #(
  parameter int unsigned STORE_DEPTH = 33,
  parameter int unsigned AW          = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ufp_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [ufp_pkg::BYTE_W-1:0]     cfg_data_i,
  input  logic                           rx_valid_i,
  output logic                           rx_stall_o,
  input  logic [ufp_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                           mem_we_o,
  output logic [AW:0]                    mem_waddr_o,
  output logic [ufp_pkg::BYTE_W-1:0]     mem_wdata_o,
  output logic                           push_o,
  output ufp_pkg::ufp_desc_t             desc_o,
  input  logic                           q_full_i,
  input  ufp_pkg::ufp_release_t          release_i
);

  typedef enum logic [2:0] {
    PH_HEAD_HIGH = 3'd0,
    PH_HEAD_LOW  = 3'd1,
    PH_LENGTH    = 3'd2,
    PH_DATA      = 3'd3,
    PH_CHECK     = 3'd4,
    PH_TAIL      = 3'd5
  } phase_e;

  localparam logic [ufp_pkg::BYTE_W-1:0] LenMax = ufp_pkg::BYTE_W'(STORE_DEPTH);

  phase_e                        phase_q, phase_d;
  logic [ufp_pkg::FIELD_W-1:0]   byte_count_q, byte_count_d;
  logic [ufp_pkg::FIELD_W-1:0]   frame_length_q, frame_length_d;
  logic [ufp_pkg::BYTE_W-1:0]    xor_q, xor_d;
  logic                          wr_bank_q, wr_bank_d;
  logic [1:0]                    busy_q, busy_d;
  logic [ufp_pkg::BYTE_W-1:0]    head_high_q, head_low_q, tail_q;
  logic                          accept;
  logic [ufp_pkg::FIELD_W-1:0]   count_inc;

  assign rx_stall_o  = (phase_q == PH_DATA) && busy_q[wr_bank_q];
  assign accept      = rx_valid_i && !rx_stall_o;
  assign count_inc   = byte_count_q + ufp_pkg::FIELD_W'(1);
  assign mem_waddr_o = {wr_bank_q, byte_count_q[AW-1:0]};
  assign mem_wdata_o = rx_byte_i;
  assign desc_o      = '{bank: wr_bank_q, len: frame_length_q};

  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    frame_length_d = frame_length_q;
    xor_d          = xor_q;
    wr_bank_d      = wr_bank_q;
    busy_d         = busy_q;
    mem_we_o       = 1'b0;
    push_o         = 1'b0;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (accept) begin
      unique case (phase_q)
        PH_HEAD_LOW: begin
          if (rx_byte_i == head_low_q) begin
            phase_d      = PH_LENGTH;
            byte_count_d = '0;
          end else if (rx_byte_i != head_high_q) begin
            phase_d = PH_HEAD_HIGH;
          end
        end
        PH_LENGTH: begin
          if (rx_byte_i != '0 && rx_byte_i <= LenMax) begin
            frame_length_d = rx_byte_i[ufp_pkg::FIELD_W-1:0];
            xor_d          = rx_byte_i;
            byte_count_d   = '0;
            phase_d        = PH_DATA;
          end else begin
            phase_d = PH_HEAD_HIGH;
          end
        end
        PH_DATA: begin
          mem_we_o     = 1'b1;
          xor_d        = xor_q ^ rx_byte_i;
          byte_count_d = count_inc;
          if (count_inc >= frame_length_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d = (rx_byte_i == xor_q) ? PH_TAIL : PH_HEAD_HIGH;
        end
        PH_TAIL: begin
          if (rx_byte_i == tail_q) begin
            push_o            = 1'b1;
            busy_d[wr_bank_q] = 1'b1;
            wr_bank_d         = !wr_bank_q;
          end
          phase_d = PH_HEAD_HIGH;
        end
        default: begin
          phase_d = (rx_byte_i == head_high_q) ? PH_HEAD_LOW : PH_HEAD_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEAD_HIGH;
      byte_count_q   <= '0;
      frame_length_q <= '0;
      xor_q          <= '0;
      wr_bank_q      <= 1'b0;
      busy_q         <= '0;
      head_high_q    <= ufp_pkg::HEAD_HIGH_RST;
      head_low_q     <= ufp_pkg::HEAD_LOW_RST;
      tail_q         <= ufp_pkg::TAIL_RST;
    end else begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      frame_length_q <= frame_length_d;
      xor_q          <= xor_d;
      wr_bank_q      <= wr_bank_d;
      busy_q         <= busy_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ufp_pkg::CFG_HEAD_HIGH: head_high_q <= cfg_data_i;
          ufp_pkg::CFG_HEAD_LOW:  head_low_q  <= cfg_data_i;
          ufp_pkg::CFG_TAIL:      tail_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_write_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> !busy_q[wr_bank_q])
    else $error("frame store write into a bank still being drained");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("frame request pushed into a full queue");
`endif

endmodule

[design/ufp_queue.sv]
// Two-entry queue of frame requests between front end and emitter.
// Depends on ufp_pkg.
module ufp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ufp_pkg::ufp_desc_t desc_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ufp_pkg::ufp_desc_t desc_o
);

  ufp_pkg::ufp_desc_t entry_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign desc_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("frame request popped from an empty queue");
`endif

endmodule

[design/ufp_back.sv]
// Emitter: drains a stored frame from the frame store into the result register.
// Depends on ufp_pkg.
module ufp_back #(
  parameter int unsigned AW = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  ufp_pkg::ufp_desc_t          q_desc_i,
  output logic                        q_pop_o,
  output logic                        mem_re_o,
  output logic [AW:0]                 mem_raddr_o,
  input  logic [ufp_pkg::BYTE_W-1:0]  mem_rdata_i,
  output ufp_pkg::ufp_release_t       release_o,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic [ufp_pkg::BYTE_W-1:0]  data_byte_o,
  output logic [ufp_pkg::FIELD_W-1:0] position_o,
  output logic [ufp_pkg::FIELD_W-1:0] payload_count_o,
  output logic                        last_o
);

  logic                        act_q, bank_q;
  logic [ufp_pkg::FIELD_W-1:0] len_q, idx_q;
  logic                        pend_q, pend_last_q;
  logic [ufp_pkg::FIELD_W-1:0] pend_pos_q, pend_cnt_q;
  logic                        out_valid_q, out_last_q;
  logic [ufp_pkg::BYTE_W-1:0]  out_data_q;
  logic [ufp_pkg::FIELD_W-1:0] out_pos_q, out_cnt_q;
  logic                        issue, is_last;
  logic [ufp_pkg::FIELD_W-1:0] idx_inc;

  assign idx_inc     = idx_q + ufp_pkg::FIELD_W'(1);
  assign is_last     = idx_inc == len_q;
  assign issue       = act_q && !pend_q && (!out_valid_q || !res_stall_i);
  assign q_pop_o     = !act_q && q_valid_i;
  assign mem_re_o    = issue;
  assign mem_raddr_o = {bank_q, idx_q[AW-1:0]};
  assign release_o   = '{valid: issue && is_last, bank: bank_q};

  assign res_valid_o     = out_valid_q;
  assign data_byte_o     = out_data_q;
  assign position_o      = out_pos_q;
  assign payload_count_o = out_cnt_q;
  assign last_o          = out_last_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      bank_q <= q_desc_i.bank;
      len_q  <= q_desc_i.len;
    end
    if (issue) begin
      pend_pos_q  <= idx_q;
      pend_last_q <= is_last;
      pend_cnt_q  <= len_q - ufp_pkg::FIELD_W'(1);
    end
    if (pend_q) begin
      out_data_q <= mem_rdata_i;
      out_pos_q  <= pend_pos_q;
      out_cnt_q  <= pend_cnt_q;
      out_last_q <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        act_q <= 1'b1;
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_inc;
        if (is_last) begin
          act_q <= 1'b0;
        end
      end
      pend_q <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_land_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("read data lands on an occupied result register");
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_pos_q == out_cnt_q))
    else $error("last result does not sit at the final payload position");
`endif

endmodule

[design/uart_frame_parser_xor.sv]
// Serial frame parser with XOR checksum: accepts one received byte per cycle
// while rx_stall_o is low and emits the payload bytes of each good frame, last
// one marked. The emitter starts a frame store read only when no earlier read
// is pending; the registered read of the frame store feeds the single result
// register. The frame store holds two banks, each taking a frame of up to
// MAX_PAYLOAD+1 bytes; the front end stalls a data byte only while the bank
// it must write still holds a frame that the emitter has not finished reading.
// Depends on ufp_pkg, ufp_ram, ufp_front, ufp_queue and ufp_back.
module uart_frame_parser_xor #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ufp_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [ufp_pkg::BYTE_W-1:0]  cfg_data_i,
  input  logic                        rx_valid_i,
  output logic                        rx_stall_o,
  input  logic [ufp_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output logic [ufp_pkg::BYTE_W-1:0]  data_byte_o,
  output logic [ufp_pkg::FIELD_W-1:0] position_o,
  output logic [ufp_pkg::FIELD_W-1:0] payload_count_o,
  output logic                        last_o
);

  localparam int unsigned StoreDepth = MAX_PAYLOAD + 1;
  localparam int unsigned Aw         = $clog2(StoreDepth);
  localparam int unsigned RamDepth   = 2 ** (Aw + 1);

  logic                       mem_we, mem_re;
  logic [Aw:0]                mem_waddr, mem_raddr;
  logic [ufp_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;
  logic                       q_push, q_full, q_pop, q_valid;
  ufp_pkg::ufp_desc_t         push_desc, head_desc;
  ufp_pkg::ufp_release_t      bank_release;

  ufp_front #(
    .STORE_DEPTH(StoreDepth),
    .AW         (Aw)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .push_o     (q_push),
    .desc_o     (push_desc),
    .q_full_i   (q_full),
    .release_i  (bank_release)
  );

  ufp_ram #(
    .WIDTH(ufp_pkg::BYTE_W),
    .DEPTH(RamDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  ufp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .desc_i (push_desc),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .desc_o (head_desc)
  );

  ufp_back #(
    .AW(Aw)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_desc_i       (head_desc),
    .q_pop_o        (q_pop),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .release_o      (bank_release),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .data_byte_o    (data_byte_o),
    .position_o     (position_o),
    .payload_count_o(payload_count_o),
    .last_o         (last_o)
  );

endmodule

[bench/tb_uart_frame_parser_xor.sv]
`timescale 1ns / 1ps
// Testbench for uart_frame_parser_xor: directed and random byte streams, good and broken
// frames, each result checked against a deframer kept in the bench.
// Depends on ufp_pkg and the design sources.
module tb_uart_frame_parser_xor;

  localparam int unsigned MAX_PAYLOAD   = 32;
  localparam int unsigned STORE_DEPTH   = MAX_PAYLOAD + 1;
  localparam logic [ufp_pkg::CFG_IW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic [2:0] {
    SEEK_HIGH, SEEK_LOW, READ_LEN, READ_BODY, READ_SUM, READ_TAIL
  } hunt_e;

  typedef struct packed {
    logic [ufp_pkg::BYTE_W-1:0]  data;
    logic [ufp_pkg::FIELD_W-1:0] pos;
    logic [ufp_pkg::FIELD_W-1:0] count;
    logic                        last;
  } frame_byte_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [ufp_pkg::CFG_IW-1:0]   cfg_index_i = '0;
  logic [ufp_pkg::BYTE_W-1:0]   cfg_data_i  = '0;
  logic                         rx_valid_i  = 1'b0;
  logic                         rx_stall_o;
  logic [ufp_pkg::BYTE_W-1:0]   rx_byte_i   = '0;
  logic                         res_valid_o;
  logic                         res_stall_i = 1'b0;
  logic [ufp_pkg::BYTE_W-1:0]   data_byte_o;
  logic [ufp_pkg::FIELD_W-1:0]  position_o;
  logic [ufp_pkg::FIELD_W-1:0]  payload_count_o;
  logic                         last_o;

  logic [ufp_pkg::BYTE_W-1:0]  head_high = ufp_pkg::HEAD_HIGH_RST;
  logic [ufp_pkg::BYTE_W-1:0]  head_low  = ufp_pkg::HEAD_LOW_RST;
  logic [ufp_pkg::BYTE_W-1:0]  tail_mark = ufp_pkg::TAIL_RST;
  hunt_e                       hunt      = SEEK_HIGH;
  logic [ufp_pkg::FIELD_W-1:0] body_cnt  = '0;
  logic [ufp_pkg::FIELD_W-1:0] body_len  = '0;
  logic [ufp_pkg::BYTE_W-1:0]  run_xor   = '0;
  logic [ufp_pkg::BYTE_W-1:0]  body_store [STORE_DEPTH];

  frame_byte_t                frame_bytes_due [$];
  logic [ufp_pkg::BYTE_W-1:0] frame_body [$];
  int unsigned                frame_items   = 0;
  int unsigned                send_idle_pct = 24;
  int unsigned                recv_idle_pct = 65;
  int unsigned                mismatches    = 0;
  int unsigned                quiet_cycles  = 0;

  uart_frame_parser_xor #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .data_byte_o    (data_byte_o),
    .position_o     (position_o),
    .payload_count_o(payload_count_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic deframe_byte(input logic [ufp_pkg::BYTE_W-1:0] b);
    frame_byte_t fb;
    case (hunt)
      SEEK_LOW: begin
        if (b == head_low) begin
          hunt = READ_LEN;
          body_cnt = '0;
        end else if (b != head_high) begin
          hunt = SEEK_HIGH;
        end
      end
      READ_LEN: begin
        if (b >= 1 && b <= STORE_DEPTH) begin
          body_len = b[ufp_pkg::FIELD_W-1:0];
          run_xor = b;
          body_cnt = '0;
          hunt = READ_BODY;
        end else begin
          hunt = SEEK_HIGH;
        end
      end
      READ_BODY: begin
        body_store[body_cnt] = b;
        run_xor = run_xor ^ b;
        body_cnt = body_cnt + 1'b1;
        if (body_cnt >= body_len) hunt = READ_SUM;
      end
      READ_SUM: hunt = (b == run_xor) ? READ_TAIL : SEEK_HIGH;
      READ_TAIL: begin
        if (b == tail_mark) begin
          for (int i = 0; i < body_len; i++) begin
            fb.data  = body_store[i];
            fb.pos   = ufp_pkg::FIELD_W'(i);
            fb.count = body_len - 1'b1;
            fb.last  = (i == body_len - 1);
            frame_bytes_due.push_back(fb);
          end
        end
        hunt = SEEK_HIGH;
      end
      default: hunt = (b == head_high) ? SEEK_LOW : SEEK_HIGH;
    endcase
  endtask

  task automatic send_byte(input logic [ufp_pkg::BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    deframe_byte(b);
  endtask

  task automatic fill_body(input int unsigned len);
    frame_body.delete();
    repeat (len) frame_body.push_back(ufp_pkg::BYTE_W'($urandom_range(255)));
  endtask

  task automatic send_frame(input bit bad_sum, input bit bad_tail, input bit echo_high);
    logic [ufp_pkg::BYTE_W-1:0] csum;
    csum = ufp_pkg::BYTE_W'(frame_body.size());
    send_byte(head_high);
    if (echo_high) send_byte(head_high);
    send_byte(head_low);
    send_byte(csum);
    foreach (frame_body[i]) begin
      send_byte(frame_body[i]);
      csum = csum ^ frame_body[i];
    end
    send_byte(bad_sum ? csum ^ ufp_pkg::BYTE_W'(1 << $urandom_range(ufp_pkg::BYTE_W - 1))
                      : csum);
    send_byte(bad_tail ? tail_mark ^ ufp_pkg::BYTE_W'($urandom_range(255, 1)) : tail_mark);
    frame_items += frame_body.size() + 5 + echo_high;
  endtask

  task automatic send_bad_length(input logic [ufp_pkg::BYTE_W-1:0] len);
    send_byte(head_high);
    send_byte(head_low);
    send_byte(len);
    frame_items += 3;
  endtask

  task automatic wait_drained;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ufp_pkg::CFG_IW-1:0] idx,
                           input logic [ufp_pkg::BYTE_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      ufp_pkg::CFG_HEAD_HIGH: head_high = val;
      ufp_pkg::CFG_HEAD_LOW:  head_low  = val;
      ufp_pkg::CFG_TAIL:      tail_mark = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [ufp_pkg::BYTE_W-1:0] hh,
                            input logic [ufp_pkg::BYTE_W-1:0] hl,
                            input logic [ufp_pkg::BYTE_W-1:0] tl);
    wait_drained;
    write_reg(ufp_pkg::CFG_HEAD_HIGH, hh);
    write_reg(ufp_pkg::CFG_HEAD_LOW, hl);
    write_reg(ufp_pkg::CFG_TAIL, tl);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_frame_limits;
    fill_body(1);
    frame_body[0] = 8'h00;
    send_frame(1'b0, 1'b0, 1'b0);
    fill_body(STORE_DEPTH);
    frame_body[0] = 8'hFF;
    frame_body[1] = 8'h00;
    send_frame(1'b0, 1'b0, 1'b0);
    rx_valid_i <= 1'b0;
  endtask

  task automatic test_dropped_frames;
    wait_drained;
    send_bad_length(8'd0);
    send_bad_length(ufp_pkg::BYTE_W'(STORE_DEPTH + 1));
    fill_body(2);
    send_frame(1'b1, 1'b0, 1'b0);
    fill_body(1);
    send_frame(1'b0, 1'b1, 1'b0);
    fill_body(3);
    send_frame(1'b0, 1'b0, 1'b1);
    rx_valid_i <= 1'b0;
  endtask

  task automatic test_ignored_index;
    wait_drained;
    write_reg(CFG_UNUSED, ~tail_mark);
    cfg_we_i <= 1'b0;
    fill_body(2);
    send_frame(1'b0, 1'b0, 1'b0);
    rx_valid_i <= 1'b0;
  endtask

  task automatic test_register_extremes;
    set_config(8'h00, 8'hFF, 8'h00);
    fill_body(2);
    send_frame(1'b0, 1'b0, 1'b0);
    fill_body(1);
    frame_body[0] = 8'hFF;
    send_frame(1'b0, 1'b0, 1'b0);
    rx_valid_i <= 1'b0;
    set_config(8'hFF, 8'h00, 8'hFF);
    fill_body(4);
    send_frame(1'b0, 1'b0, 1'b0);
    rx_valid_i <= 1'b0;
  endtask

  task automatic test_equal_headers;
    set_config(8'h5A, 8'h5A, 8'hA5);
    fill_body(2);
    send_frame(1'b0, 1'b0, 1'b0);
    send_frame(1'b0, 1'b0, 1'b1);
    fill_body(3);
    send_frame(1'b0, 1'b0, 1'b0);
    rx_valid_i <= 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_idle,
                                     input int unsigned rx_idle);
    int unsigned pick;
    int unsigned len;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    frame_items   = 0;
    while (frame_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) len = STORE_DEPTH;
      else if (pick < 12) len = $urandom_range(STORE_DEPTH - 1, 9);
      else len = $urandom_range(8, 1);
      fill_body(len);
      pick = $urandom_range(99);
      if (pick < 70) send_frame(1'b0, 1'b0, 1'b0);
      else if (pick < 78) send_frame(1'b1, 1'b0, 1'b0);
      else if (pick < 85) send_frame(1'b0, 1'b1, 1'b0);
      else if (pick < 91) send_frame(1'b0, 1'b0, 1'b1);
      else if (pick < 96)
        send_bad_length($urandom_range(1) ? 8'd0 :
                        ufp_pkg::BYTE_W'($urandom_range(255, STORE_DEPTH + 1)));
      else begin
        len = $urandom_range(4, 1);
        repeat (len) send_byte(ufp_pkg::BYTE_W'($urandom_range(255)));
        frame_items += len;
      end
    end
    rx_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_side
    frame_byte_t want;
    res_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (frame_bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte %0d pos %0d count %0d last %0b",
                   data_byte_o, position_o, payload_count_o, last_o);
      end else begin
        want = frame_bytes_due.pop_front();
        if (data_byte_o !== want.data || position_o !== want.pos ||
            payload_count_o !== want.count || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: got byte %0d pos %0d count %0d last %0b, %s",
                     data_byte_o, position_o, payload_count_o, last_o,
                     $sformatf("expected byte %0d pos %0d count %0d last %0b",
                               want.data, want.pos, want.count, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid_i && !rx_stall_o) || (res_valid_o && !res_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_limits;
    test_dropped_frames;
    test_ignored_index;
    test_register_extremes;
    test_equal_headers;
    set_config(ufp_pkg::HEAD_HIGH_RST, ufp_pkg::HEAD_LOW_RST, ufp_pkg::TAIL_RST);
    test_random_traffic(100, 24, 65);
    set_config(ufp_pkg::BYTE_W'($urandom_range(255)), ufp_pkg::BYTE_W'($urandom_range(255)),
               ufp_pkg::BYTE_W'($urandom_range(255)));
    test_random_traffic(100, 65, 24);
    set_config(ufp_pkg::BYTE_W'($urandom_range(255)), ufp_pkg::BYTE_W'($urandom_range(255)),
               ufp_pkg::BYTE_W'($urandom_range(255)));
    test_random_traffic(90, 0, 0);
    wait_drained;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
